>>> rtl/lcfp_pkg.sv
// ----------------------------------------------------------------------------
// lcfp_pkg
// Shared types and byte codes for the lamp command frame parser.
// ----------------------------------------------------------------------------
package lcfp_pkg;

  // Frame header and trailer bytes
  localparam logic [7:0] HdrColour = 8'h0d;
  localparam logic [7:0] HdrAuto   = 8'h03;
  localparam logic [7:0] HdrNight  = 8'h02;
  localparam logic [7:0] HdrFade   = 8'h04;
  localparam logic [7:0] HdrOpen   = 8'haa;
  localparam logic [7:0] HdrClose  = 8'hcc;
  localparam logic [7:0] Trailer   = 8'h0a;

  // Setting named by one result word
  typedef enum logic [3:0] {
    KIND_NONE    = 4'd0,
    KIND_RED     = 4'd1,
    KIND_GREEN   = 4'd2,
    KIND_BLUE    = 4'd3,
    KIND_POWER   = 4'd4,
    KIND_AUTO    = 4'd5,
    KIND_NIGHT   = 4'd6,
    KIND_OPEN_H  = 4'd7,
    KIND_OPEN_M  = 4'd8,
    KIND_CLOSE_H = 4'd9,
    KIND_CLOSE_M = 4'd10,
    KIND_FADE    = 4'd11
  } kind_e;

  // One decoded result word
  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       change_flag;
    logic       frame_end;
  } result_t;

endpackage

>>> rtl/lcfp_fsm.sv
// ----------------------------------------------------------------------------
// lcfp_fsm
// Parser state register and the per-byte decode of header, payload and
// trailer bytes. The result is combinational from the state and the byte;
// the state steps when the caller commits the byte.
// ----------------------------------------------------------------------------
module lcfp_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        byte_i,
  input  logic              advance_i,
  output lcfp_pkg::result_t result_o
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_RED     = 4'd1,
    ST_GREEN   = 4'd2,
    ST_BLUE    = 4'd3,
    ST_POWER   = 4'd4,
    ST_AUTO    = 4'd5,
    ST_NIGHT   = 4'd6,
    ST_OPEN_H  = 4'd7,
    ST_OPEN_M  = 4'd8,
    ST_CLOSE_H = 4'd9,
    ST_CLOSE_M = 4'd10,
    ST_FADE    = 4'd11,
    ST_TRAILER = 4'd12
  } state_e;

  state_e state_q, state_d;

  // Next state and result for the current byte
  always_comb begin
    state_d              = state_q;
    result_o.kind        = lcfp_pkg::KIND_NONE;
    result_o.value       = 8'h00;
    result_o.change_flag = 1'b0;
    result_o.frame_end   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        case (byte_i)
          lcfp_pkg::HdrColour: state_d = ST_RED;
          lcfp_pkg::HdrAuto:   state_d = ST_AUTO;
          lcfp_pkg::HdrNight:  state_d = ST_NIGHT;
          lcfp_pkg::HdrOpen:   state_d = ST_OPEN_H;
          lcfp_pkg::HdrClose:  state_d = ST_CLOSE_H;
          lcfp_pkg::HdrFade:   state_d = ST_FADE;
          default:             state_d = ST_IDLE;
        endcase
      end
      ST_RED: begin
        result_o.kind  = lcfp_pkg::KIND_RED;
        result_o.value = byte_i;
        state_d        = ST_GREEN;
      end
      ST_GREEN: begin
        result_o.kind  = lcfp_pkg::KIND_GREEN;
        result_o.value = byte_i;
        state_d        = ST_BLUE;
      end
      ST_BLUE: begin
        result_o.kind  = lcfp_pkg::KIND_BLUE;
        result_o.value = byte_i;
        state_d        = ST_POWER;
      end
      ST_POWER: begin
        result_o.kind  = lcfp_pkg::KIND_POWER;
        result_o.value = byte_i;
        state_d        = ST_TRAILER;
      end
      ST_AUTO: begin
        result_o.kind        = lcfp_pkg::KIND_AUTO;
        result_o.value       = byte_i;
        result_o.change_flag = 1'b1;
        state_d              = ST_TRAILER;
      end
      ST_NIGHT: begin
        result_o.kind        = lcfp_pkg::KIND_NIGHT;
        result_o.value       = byte_i;
        result_o.change_flag = 1'b1;
        state_d              = ST_TRAILER;
      end
      ST_OPEN_H: begin
        result_o.kind  = lcfp_pkg::KIND_OPEN_H;
        result_o.value = byte_i;
        state_d        = ST_OPEN_M;
      end
      ST_OPEN_M: begin
        result_o.kind        = lcfp_pkg::KIND_OPEN_M;
        result_o.value       = byte_i;
        result_o.change_flag = 1'b1;
        state_d              = ST_TRAILER;
      end
      ST_CLOSE_H: begin
        result_o.kind  = lcfp_pkg::KIND_CLOSE_H;
        result_o.value = byte_i;
        state_d        = ST_CLOSE_M;
      end
      ST_CLOSE_M: begin
        result_o.kind        = lcfp_pkg::KIND_CLOSE_M;
        result_o.value       = byte_i;
        result_o.change_flag = 1'b1;
        state_d              = ST_TRAILER;
      end
      ST_FADE: begin
        result_o.kind        = lcfp_pkg::KIND_FADE;
        result_o.value       = byte_i;
        result_o.change_flag = 1'b1;
        state_d              = ST_TRAILER;
      end
      ST_TRAILER: begin
        if (byte_i == lcfp_pkg::Trailer) begin
          result_o.frame_end = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      // unreachable codes drop back to idle
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

  // Payload states always name a setting, idle and the trailer wait never do
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_TRAILER) |-> result_o.kind == lcfp_pkg::KIND_NONE)
    else $error("lcfp_fsm: update reported outside a payload state");

  // Frame end only leaves the trailer wait for idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && result_o.frame_end) |=> state_q == ST_IDLE)
    else $error("lcfp_fsm: frame end did not return to idle");

  // A committed payload byte never lands directly in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && result_o.kind != lcfp_pkg::KIND_NONE) |=> state_q != ST_IDLE)
    else $error("lcfp_fsm: payload byte returned to idle");

endmodule

>>> rtl/lamp_command_frame_parser.sv
// ----------------------------------------------------------------------------
// lamp_command_frame_parser
// Serial byte stream to lamp setting updates, one result word per byte.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle while the output is not stalled, and
// each gives exactly one result word: the byte is captured in an input register,
// decoded combinationally against the parser state, and held in a result
// register until taken. The combinational state decode sets the rate of one byte
// per cycle; a stalled output holds the input register, and the input side keeps
// taking bytes whenever the input register is empty or the result register is
// free or being emptied.
module lamp_command_frame_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] update_kind_o,
  output logic [7:0] update_value_o,
  output logic       change_flag_o,
  output logic       frame_end_o
);

  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              out_free;
  logic              advance;
  lcfp_pkg::result_t result;
  lcfp_pkg::result_t result_q;

  // Handshake between stages
  assign out_free   = !out_valid_o || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  // Decode
  lcfp_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_q),
    .advance_i (advance),
    .result_o  (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign update_kind_o  = result_q.kind;
  assign update_value_o = result_q.value;
  assign change_flag_o  = result_q.change_flag;
  assign frame_end_o    = result_q.frame_end;

  // A stalled input word stays put while the result register is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(byte_q)))
    else $error("lamp_command_frame_parser: stalled input word lost");

  // Frame end comes only with no setting update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> update_kind_o == lcfp_pkg::KIND_NONE)
    else $error("lamp_command_frame_parser: frame end with an update");

  // No update carries a zero value and no change flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && update_kind_o == lcfp_pkg::KIND_NONE)
      |-> (update_value_o == 8'h00 && !change_flag_o))
    else $error("lamp_command_frame_parser: empty word carries data");

  // Change flag only on the flagged settings
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && change_flag_o)
      |-> (update_kind_o == lcfp_pkg::KIND_AUTO || update_kind_o == lcfp_pkg::KIND_NIGHT ||
           update_kind_o == lcfp_pkg::KIND_OPEN_M || update_kind_o == lcfp_pkg::KIND_CLOSE_M ||
           update_kind_o == lcfp_pkg::KIND_FADE))
    else $error("lamp_command_frame_parser: change flag on unflagged setting");

endmodule
